// ===== src/pawu_pkg.sv =====
// shared types and constants for the proximal adam weight update block
package pawu_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned SqOpW  = 48;
  localparam int unsigned RootW  = 24;
  localparam int unsigned DvdW   = 64;
  localparam int unsigned DenW   = 25;

  localparam logic [16:0] QOne = 17'h10000;

  localparam logic [1:0] CfgBetaOne  = 2'd0;
  localparam logic [1:0] CfgBetaTwo  = 2'd1;
  localparam logic [1:0] CfgStepSize = 2'd2;
  localparam logic [1:0] CfgLambda   = 2'd3;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } store_entry_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_RD, ST_LD, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
    ST_M7, ST_SQ, ST_DV, ST_FIN, ST_WB
  } state_t;

endpackage

// ===== src/pawu_store.sv =====
// entry memory holding weight, first moment and second moment side by side
module pawu_store import pawu_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 1024,
  parameter int unsigned AW = 10
) (
  input  logic         clk,
  input  logic [AW-1:0] rd_addr,
  output store_entry_t rd_data,
  input  logic         wr_en,
  input  logic [AW-1:0] wr_addr,
  input  store_entry_t wr_data
);

  store_entry_t mem [NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/pawu_isqrt.sv =====
// bit-serial integer square root, two operand bits per cycle
module pawu_isqrt import pawu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SqOpW-1:0] op,
  output logic             busy,
  output logic [RootW-1:0] root
);

  logic [SqOpW-1:0] x;
  logic [25:0]      rem;
  logic [4:0]       cnt;
  logic [27:0]      rem_sh;
  logic [27:0]      trial;
  logic             fits;

  always_comb begin
    rem_sh = {rem, x[SqOpW-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(RootW);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= op;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x <= {x[SqOpW-3:0], 2'b00};
      if (fits) begin
        rem  <= 26'(rem_sh - trial);
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[25:0];
        root <= {root[RootW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/pawu_div.sv =====
// restoring divider, one quotient bit per cycle
module pawu_div import pawu_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DvdW-1:0] dividend,
  input  logic [DenW-1:0] divisor,
  output logic            busy,
  output logic [DvdW-1:0] quotient
);

  logic [DenW-1:0] den;
  logic [DenW-1:0] rem;
  logic [6:0]      cnt;
  logic [DenW:0]   rem_sh;
  logic            fits;

  always_comb begin
    rem_sh = {rem, quotient[DvdW-1]};
    fits   = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'(DvdW);
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem      <= DenW'(rem_sh - {1'b0, den});
        quotient <= {quotient[DvdW-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DenW-1:0];
        quotient <= {quotient[DvdW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/proximal_adam_weight_update.sv =====
// proximal adam weight update: sequencer, shared multiplier and write-back
// Usage:
// - input channel (in_valid/in_stall) takes one word: weight_index and a Q16.16
//   gradient. The entry's weight and both moments are read, updated, written
//   back, and one output word (updated_index, new_weight, saturated) follows.
// - one item is in work at a time; in_stall is high from acceptance until the
//   result is written back. The output word becomes valid in the same cycle
//   as the input opens again. The work runs in order: read, seven passes
//   through the shared 33x33 multiplier, a 24-step square root and a 64-step
//   divider, then threshold and write-back.
// - the result sits in an output register; while out_stall holds it, the next
//   item can be accepted and worked on, and it waits before write-back until
//   the output register is free.
// - indexes at or past NUM_ENTRIES change nothing and return weight 0.
// - configuration writes (cfg_write, cfg_index, cfg_data) go to the registers
//   at once; write them only while the block is idle.
// - after reset a clearing pass zeroes every entry in turn, with in_stall
//   high; configuration is taken during the pass.
module proximal_adam_weight_update import pawu_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IdxW-1:0]       weight_index,
  input  logic signed [31:0]    gradient,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IdxW-1:0]       updated_index,
  output logic signed [31:0]    new_weight,
  output logic                  saturated,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int unsigned AW = $clog2(NUM_ENTRIES);
  localparam logic [16:0] NumE = 17'(NUM_ENTRIES);

  state_t state, state_next;

  logic [15:0] beta_one, beta_two;
  logic [31:0] learn_rate, lambda;

  logic [IdxW-1:0]    idx;
  logic               oor;
  logic signed [31:0] grad;
  logic signed [31:0] w_cur, v_cur, u_new, v_new, gsq, wn;
  logic               sat;
  logic signed [51:0] acc;
  logic signed [64:0] num;
  logic [48:0]        thr;
  logic [AW-1:0]      clr_addr;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  store_entry_t       rd_data, wr_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;

  logic               sq_start, sq_busy, dv_start, dv_busy;
  logic [RootW-1:0]   root;
  logic [DvdW-1:0]    quot;
  logic [DvdW-1:0]    num_abs;
  logic [DenW-1:0]    den;

  logic [16:0]        idx_wide;
  logic               in_range, accept, out_free;
  logic [16:0]        one_m_b1, one_m_b2;
  logic [32:0]        u_rc, v_rc;
  logic [63:0]        gsq_r;
  logic               big;
  logic [33:0]        qc;
  logic signed [49:0] wsum, wsoft, thr_s;
  logic signed [35:0] delta;

  // round half up by 2^16 and clip to 32 bits; top bit flags a clip
  function automatic logic [32:0] round_clip(input logic signed [51:0] a);
    logic signed [51:0] s;
    s = (a + 52'sd32768) >>> 16;
    if (s > 52'sd2147483647) begin
      return {1'b1, 32'h7fffffff};
    end else if (s < -52'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, s[31:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_one   <= 16'd58982;
      beta_two   <= 16'd65470;
      learn_rate <= 32'd66;
      lambda     <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgBetaOne:  beta_one   <= cfg_data[15:0];
        CfgBetaTwo:  beta_two   <= cfg_data[15:0];
        CfgStepSize: learn_rate <= cfg_data;
        CfgLambda:   lambda     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign idx_wide = {{(17-IdxW){1'b0}}, weight_index};
  assign in_range = idx_wide < NumE;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign one_m_b1 = QOne - {1'b0, beta_one};
  assign one_m_b2 = QOne - {1'b0, beta_two};
  assign rd_addr  = AW'({{(17-IdxW){1'b0}}, idx});

  pawu_store #(.NUM_ENTRIES(NUM_ENTRIES), .AW(AW)) u_store (
    .clk, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  pawu_isqrt u_isqrt (
    .clk, .rst, .start(sq_start), .op({v_new, 16'b0}), .busy(sq_busy), .root
  );

  pawu_div u_div (
    .clk, .rst, .start(dv_start), .dividend(num_abs), .divisor(den),
    .busy(dv_busy), .quotient(quot)
  );

  // shared multiplier operand select, product registered
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_LD: begin ma = {17'b0, beta_one}; mb = {rd_data.u[31], rd_data.u}; end
      ST_M1: begin ma = {16'b0, one_m_b1}; mb = {grad[31], grad}; end
      ST_M2: begin ma = {grad[31], grad};  mb = {grad[31], grad}; end
      ST_M3: begin ma = {17'b0, beta_two}; mb = {v_cur[31], v_cur}; end
      ST_M4: begin ma = {16'b0, one_m_b2}; mb = {gsq[31], gsq}; end
      ST_M5: begin ma = {1'b0, learn_rate}; mb = {u_new[31], u_new}; end
      ST_M6: begin ma = {1'b0, lambda};    mb = {1'b0, learn_rate}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_comb begin
    u_rc    = round_clip(acc);
    v_rc    = round_clip(acc);
    gsq_r   = (prod[63:0] + 64'd32768) >> 16;
    num_abs = num[64] ? DvdW'(-num) : num[63:0];
    den     = {1'b0, root} + DenW'(1);
    big     = (|quot[63:34]) || (quot[33] && (|quot[32:0]));
    qc      = big ? 34'h200000000 : quot[33:0];
    delta   = num[64] ? $signed({2'b00, qc}) : -$signed({2'b00, qc});
    wsum    = 50'(w_cur) + 50'(delta);
    thr_s   = $signed({1'b0, thr});
    if (wsum > thr_s) begin
      wsoft = wsum - thr_s;
    end else if (wsum < -thr_s) begin
      wsoft = wsum + thr_s;
    end else begin
      wsoft = '0;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    dv_start   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = rd_addr;
    wr_data    = '{w: wn, u: u_new, v: v_new};
    unique case (state)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == AW'(NUM_ENTRIES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: if (accept) state_next = in_range ? ST_RD : ST_WB;
      ST_RD:   state_next = ST_LD;
      ST_LD:   state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = ST_M5;
      ST_M5:   state_next = ST_M6;
      ST_M6:   state_next = ST_M7;
      // v_new is settled here, so the root starts now
      ST_M7: begin
        sq_start   = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: if (!sq_busy) begin
        dv_start   = 1'b1;
        state_next = ST_DV;
      end
      ST_DV:   if (!dv_busy) state_next = ST_FIN;
      ST_FIN:  state_next = ST_WB;
      ST_WB: if (out_free) begin
        wr_en      = !oor;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (accept) begin
        idx  <= weight_index;
        grad <= gradient;
        oor  <= !in_range;
        sat  <= 1'b0;
        wn   <= '0;
      end
      ST_LD: begin
        w_cur <= rd_data.w;
        v_cur <= rd_data.v;
      end
      ST_M1: acc <= prod[51:0];
      ST_M2: acc <= acc + prod[51:0];
      ST_M3: begin
        u_new <= u_rc[31:0];
        if (gsq_r[47:31] != '0) begin
          gsq <= 32'h7fffffff;
        end else begin
          gsq <= gsq_r[31:0];
        end
        sat <= sat | u_rc[32] | (gsq_r[47:31] != '0);
      end
      ST_M4: acc <= prod[51:0];
      ST_M5: acc <= acc + prod[51:0];
      ST_M6: begin
        v_new <= v_rc[31] ? 32'sd0 : v_rc[31:0];
        if (v_rc[32]) sat <= 1'b1;
        num <= prod[64:0];
      end
      ST_M7: thr <= prod[64:16] + {48'b0, prod[15]};
      ST_FIN: begin
        if (wsoft > 50'sd2147483647) begin
          wn  <= 32'h7fffffff;
          sat <= 1'b1;
        end else if (wsoft < -50'sd2147483648) begin
          wn  <= 32'h80000000;
          sat <= 1'b1;
        end else begin
          wn  <= wsoft[31:0];
          sat <= sat | big;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WB && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WB && out_free) begin
      updated_index <= idx;
      new_weight    <= wn;
      saturated     <= sat;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted word did not start work");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLR |-> in_stall)
    else $error("input open during clearing pass");

  a_write_only_wb_clr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_WB || state == ST_CLR))
    else $error("memory written outside write-back or clearing");

  a_result_after_wb: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB && out_free) |=> out_valid)
    else $error("write-back without a result");

endmodule
